>>> design/rpg_pkg.sv
package rpg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AZ_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_LIMIT    = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int POWER_W    = 16;
  localparam int DOPPLER_W  = 16;
  localparam int ANGLE_Q_W  = 15;

  // CORDIC constants; angles are in units of 2^-30 rad.
  localparam int GUARD_BITS = 24;
  localparam int MAX_STAGES = 24;
  localparam int TAB_W      = 31;
  localparam int ANG_W      = 32;
  localparam int ZACC_W     = 33;

  localparam logic [ANG_W-1:0] PI_U30      = 32'd3373259426;
  localparam logic [TAB_W-1:0] HALF_PI_U30 = 31'd1686629713;
  localparam logic [ANG_W-1:0] ROUND_HALF  = 32'd65536;

  localparam logic [TAB_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
    31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
    31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128
  };

endpackage

>>> design/rpg_in_if.sv
interface rpg_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [15:0]            power_in;
  logic signed [15:0]            doppler_in;
  logic                          last_in;

  modport source (output valid, pos_x, pos_y, pos_z, power_in, doppler_in, last_in,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, power_in, doppler_in, last_in,
                output ready);
endinterface

>>> design/rpg_out_if.sv
interface rpg_out_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic                          keep;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic signed [15:0]            out_power;
  logic signed [15:0]            out_doppler;
  logic                          last_out;

  modport source (output valid, keep, out_x, out_y, out_z, out_power, out_doppler,
                  last_out, input ready);
  modport sink (input valid, keep, out_x, out_y, out_z, out_power, out_doppler,
                last_out, output ready);
endinterface

>>> design/rpg_cfg_if.sv
interface rpg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpg_pkg::CFG_IDX_W-1:0]  index;
  logic [rpg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/rpg_sqrt.sv
module rpg_sqrt #(
  parameter int RW   = 16,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [2*RW-1:0] sq_sum,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [RW-1:0]   root,
  output logic [SB_W-1:0] out_sb
);
  localparam int VW = 2 * RW;

  logic            vld_r  [0:RW];
  logic [VW-1:0]   rem_r  [0:RW];
  logic [RW-1:0]   root_r [0:RW];
  logic [SB_W-1:0] sb_r   [0:RW];

  // Entry register holds the radicand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= sq_sum;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  // One root bit per stage, most significant first.
  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int K = RW - 1 - j;
    logic [VW-1:0] trial;
    logic          fits;

    assign trial = ({{(VW-RW){1'b0}}, root_r[j]} << (K + 1))
                 | ({{(VW-1){1'b0}}, 1'b1} << (2 * K));
    assign fits  = rem_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1]  <= fits ? rem_r[j] - trial : rem_r[j];
        root_r[j+1] <= fits ? (root_r[j] | ({{(RW-1){1'b0}}, 1'b1} << K)) : root_r[j];
        sb_r[j+1]   <= sb_r[j];
      end
    end
  end

  assign out_vld = vld_r[RW];
  assign root    = root_r[RW];
  assign out_sb  = sb_r[RW];

endmodule

>>> design/rpg_cordic.sv
module rpg_cordic #(
  parameter int A_W    = 16,
  parameter int STAGES = 16,
  parameter int SB_W   = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [A_W-1:0]           a,
  input  logic [A_W-1:0]           b,
  input  logic [SB_W-1:0]          in_sb,
  output logic                     out_vld,
  output logic [rpg_pkg::TAB_W-1:0] ang,
  output logic [SB_W-1:0]          out_sb
);
  import rpg_pkg::*;

  localparam int XW = A_W + GUARD_BITS + 3;

  logic                     vld_r [0:STAGES];
  logic signed [XW-1:0]     x_r   [0:STAGES];
  logic signed [XW-1:0]     y_r   [0:STAGES];
  logic signed [ZACC_W-1:0] z_r   [0:STAGES];
  logic [SB_W-1:0]          sb_r  [0:STAGES];
  logic signed [ZACC_W-1:0] z_last;

  // Operands scaled up by the guard bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]  <= signed'({3'b000, a, {GUARD_BITS{1'b0}}});
      y_r[0]  <= signed'({3'b000, b, {GUARD_BITS{1'b0}}});
      z_r[0]  <= '0;
      sb_r[0] <= in_sb;
    end
  end

  // Vectoring stages: drive y towards zero, accumulating the angle.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ZACC_W-1:0] step;
    logic                     pos;

    assign step = signed'({{(ZACC_W-TAB_W){1'b0}}, ATAN_TAB[i]});
    assign pos  = y_r[i] > 0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]  <= pos ? x_r[i] + (y_r[i] >>> i) : x_r[i] - (y_r[i] >>> i);
        y_r[i+1]  <= pos ? y_r[i] - (x_r[i] >>> i) : y_r[i] + (x_r[i] >>> i);
        z_r[i+1]  <= pos ? z_r[i] + step : z_r[i] - step;
        sb_r[i+1] <= sb_r[i];
      end
    end
  end

  // Clamp the angle to the first quadrant.
  assign z_last = z_r[STAGES];
  always_comb begin
    priority if (z_last < 0) begin
      ang = '0;
    end else if (z_last > signed'({{(ZACC_W-TAB_W){1'b0}}, HALF_PI_U30})) begin
      ang = HALF_PI_U30;
    end else begin
      ang = z_last[TAB_W-1:0];
    end
  end

  assign out_vld = vld_r[STAGES];
  assign out_sb  = sb_r[STAGES];

endmodule

>>> design/radar_point_gate.sv
// Field-of-view and power gate for radar detections. Each transfer on in_ch
// carries one point; each transfer on out_ch returns that point unchanged with
// a keep flag, in arrival order. A point is kept when its power is at least
// the power floor register and its azimuth and elevation magnitudes (Q2.13 rad)
// are strictly below the azimuth and elevation limit registers. Throughput is
// one point per clock while the output is not stalled. In order, the pipeline
// registers magnitudes, squares, the bit-per-stage square root, the two
// parallel CORDIC pipelines and the gate compare. The pipeline holds when the
// output is stalled.
// Configuration writes are always taken and are used at the gate compare, so
// they should only be made while no point is inside the pipeline.
module radar_point_gate #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic      clk,
  input logic      rst_n,
  rpg_in_if.sink   in_ch,
  rpg_out_if.source out_ch,
  rpg_cfg_if.sink  cfg_ch
);
  import rpg_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int NSTG   = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
  localparam int PL_W   = 3 * CW + POWER_W + DOPPLER_W + 1;
  localparam int SQSB_W = 3 * CW + PL_W;

  logic adv;

  logic signed [POWER_W-1:0]  power_floor_r;
  logic [ANGLE_Q_W-1:0]       az_limit_r;
  logic [ANGLE_Q_W-1:0]       el_limit_r;

  logic            s1_vld_r, s2_vld_r;
  logic [CW-1:0]   ax_r, ay_r, az_r;
  logic [PL_W-1:0] s1_pl_r, s2_pl_r;
  logic [CW-1:0]   s2_ax_r, s2_ay_r, s2_az_r;
  logic [2*CW-1:0] sqx_r, sqy_r, sqz_r;
  logic [PL_W-1:0] in_pl;

  logic            sq_vld;
  logic [CW-1:0]   root;
  logic [SQSB_W-1:0] sq_sb;
  logic [CW-1:0]   q_ax, q_ay, q_az;
  logic [PL_W-1:0] q_pl;

  logic            az_vld, el_vld;
  logic [TAB_W-1:0] az_ang, el_ang;
  logic            az_xneg;
  logic [PL_W-1:0] el_pl;

  logic [ANG_W-1:0] az_full, az_rnd, el_rnd;
  logic             keep_nxt;

  logic            vld_r;
  logic            keep_r;
  logic [PL_W-1:0] out_pl_r;

  // Whole pipeline moves together unless a finished point is held.
  assign adv         = !vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_floor_r <= 16'sh8000;
      az_limit_r    <= 15'd25736;
      el_limit_r    <= 15'd25736;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_POWER_FLOOR: power_floor_r <= signed'(cfg_ch.data);
        CFG_AZ_LIMIT:    az_limit_r    <= cfg_ch.data[ANGLE_Q_W-1:0];
        CFG_EL_LIMIT:    el_limit_r    <= cfg_ch.data[ANGLE_Q_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pl = {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.power_in,
                  in_ch.doppler_in, in_ch.last_in};

  // Stage 1: coordinate magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r    <= in_ch.pos_x[CW-1] ? CW'(-in_ch.pos_x) : CW'(in_ch.pos_x);
      ay_r    <= in_ch.pos_y[CW-1] ? CW'(-in_ch.pos_y) : CW'(in_ch.pos_y);
      az_r    <= in_ch.pos_z[CW-1] ? CW'(-in_ch.pos_z) : CW'(in_ch.pos_z);
      s1_pl_r <= in_pl;
    end
  end

  // Stage 2: squares.
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= ax_r * ax_r;
      sqy_r   <= ay_r * ay_r;
      sqz_r   <= az_r * az_r;
      s2_ax_r <= ax_r;
      s2_ay_r <= ay_r;
      s2_az_r <= az_r;
      s2_pl_r <= s1_pl_r;
    end
  end

  // Range: floor square root of the summed squares.
  rpg_sqrt #(.RW(CW), .SB_W(SQSB_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s2_vld_r),
    .sq_sum  (sqx_r + sqy_r + sqz_r),
    .in_sb   ({s2_ax_r, s2_ay_r, s2_az_r, s2_pl_r}),
    .out_vld (sq_vld),
    .root    (root),
    .out_sb  (sq_sb)
  );

  assign {q_ax, q_ay, q_az, q_pl} = sq_sb;

  // Azimuth magnitude from |x| and |y|.
  rpg_cordic #(.A_W(CW), .STAGES(NSTG), .SB_W(1)) u_cordic_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (sq_vld),
    .a       (q_ax),
    .b       (q_ay),
    .in_sb   (q_pl[PL_W-1]),
    .out_vld (az_vld),
    .ang     (az_ang),
    .out_sb  (az_xneg)
  );

  // Elevation magnitude from the range and |z|.
  rpg_cordic #(.A_W(CW), .STAGES(NSTG), .SB_W(PL_W)) u_cordic_el (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (sq_vld),
    .a       (root),
    .b       (q_az),
    .in_sb   (q_pl),
    .out_vld (el_vld),
    .ang     (el_ang),
    .out_sb  (el_pl)
  );

  // Gate: points behind take pi minus the azimuth, then round to Q2.13.
  assign az_full  = az_xneg ? PI_U30 - {1'b0, az_ang} : {1'b0, az_ang};
  assign az_rnd   = az_full + ROUND_HALF;
  assign el_rnd   = {1'b0, el_ang} + ROUND_HALF;
  assign keep_nxt = (signed'(el_pl[PL_W-3*CW-1 -: POWER_W]) >= power_floor_r)
                 && (az_rnd[ANG_W-1:17] < az_limit_r)
                 && (el_rnd[ANG_W-1:17] < el_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= az_vld && el_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      keep_r   <= keep_nxt;
      out_pl_r <= el_pl;
    end
  end

  assign out_ch.valid = vld_r;
  assign out_ch.keep  = keep_r;
  assign {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_power,
          out_ch.out_doppler, out_ch.last_out} = out_pl_r;

endmodule

>>> bench/tb_top.sv
module tb_top;
  import rpg_pkg::*;

  localparam int COORD_W      = 16;
  localparam int CORDIC_N     = 16;
  localparam int STAGES       = (CORDIC_N < MAX_STAGES) ? CORDIC_N : MAX_STAGES;
  localparam int LATENCY      = COORD_W + STAGES + 5;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_POINTS = 150;

  // Index outside the register map; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                      keep;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [15:0]        power;
    logic signed [15:0]        doppler;
    logic                      last;
  } point_t;

  // Predicts the gate decision for every accepted point and checks results in order.
  class gate_scoreboard;
    logic signed [15:0] power_floor;
    logic [14:0]        az_limit;
    logic [14:0]        el_limit;
    point_t             pending[$];
    int                 mismatches;

    function new();
      power_floor = 16'sh8000;
      az_limit    = 15'd25736;
      el_limit    = 15'd25736;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_POWER_FLOOR: power_floor = data;
        CFG_AZ_LIMIT:    az_limit = data[14:0];
        CFG_EL_LIMIT:    el_limit = data[14:0];
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC of atan2(b, a) for a, b >= 0 in units of 2^-30 rad.
    function longint vector_angle(longint a, longint b);
      longint xs, ys, zs, dx, dy;
      if (a == 0 && b == 0) return 0;
      xs = a <<< GUARD_BITS;
      ys = b <<< GUARD_BITS;
      zs = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (ys > 0) begin
          xs += dx; ys -= dy; zs += longint'(ATAN_TAB[i]);
        end else begin
          xs -= dx; ys += dy; zs -= longint'(ATAN_TAB[i]);
        end
      end
      if (zs < 0) zs = 0;
      if (zs > longint'(HALF_PI_U30)) zs = longint'(HALF_PI_U30);
      return zs;
    endfunction

    function longint int_root(longint unsigned v);
      longint unsigned res, probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return longint'(res);
    endfunction

    function void note_point(point_t p);
      longint ax, ay, az, ang, rad, az_q, el_q;
      ax = (p.x < 0) ? -longint'(p.x) : longint'(p.x);
      ay = (p.y < 0) ? -longint'(p.y) : longint'(p.y);
      az = (p.z < 0) ? -longint'(p.z) : longint'(p.z);
      ang = vector_angle(ax, ay);
      if (p.x < 0) ang = longint'(PI_U30) - ang;
      az_q = (ang + 65536) >>> 17;
      rad = int_root(ax * ax + ay * ay + az * az);
      el_q = (vector_angle(rad, az) + 65536) >>> 17;
      p.keep = (p.power >= power_floor) && (az_q < longint'(az_limit))
               && (el_q < longint'(el_limit));
      pending = {pending, p};
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(point_t got);
      point_t exp_p;
      if (pending.size() == 0) begin
        report_mismatch("result transfer with no point outstanding");
        return;
      end
      exp_p = pending.pop_front();
      if (got !== exp_p)
        report_mismatch($sformatf(
          {"got keep %0b xyz %0d %0d %0d pw %0d dop %0d last %0b, ",
           "expected %0b %0d %0d %0d %0d %0d %0b"},
          got.keep, got.x, got.y, got.z, got.power, got.doppler, got.last,
          exp_p.keep, exp_p.x, exp_p.y, exp_p.z, exp_p.power, exp_p.doppler, exp_p.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  int   idle_cycles;
  int   out_hold;
  gate_scoreboard sb;

  rpg_in_if  #(.COORD_WIDTH(COORD_W)) in_ch ();
  rpg_out_if #(.COORD_WIDTH(COORD_W)) out_ch ();
  rpg_cfg_if cfg_ch ();

  radar_point_gate #(.COORD_WIDTH(COORD_W), .CORDIC_STAGES(CORDIC_N)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: sample transfers at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.keep, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                       out_ch.out_power, out_ch.out_doppler, out_ch.last_out});
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task send_point(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z,
                  logic signed [15:0] pw, logic signed [15:0] dop, logic lst);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.pos_x      <= x;
    in_ch.pos_y      <= y;
    in_ch.pos_z      <= z;
    in_ch.power_in   <= pw;
    in_ch.doppler_in <= dop;
    in_ch.last_in    <= lst;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point({1'b0, x, y, z, pw, dop, lst});
    // Occasional gap on the input side.
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       return 16'sd0;
      default: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    endcase
  endfunction

  task random_points(int count);
    logic signed [15:0] pw;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) pw = 16'($urandom);
      else pw = sb.power_floor + $signed(16'($urandom_range(0, 8))) - 16'sd4;
      send_point(pick_coord(), pick_coord(), pick_coord(), pw, 16'($urandom),
                 $urandom_range(0, 9) == 0);
    end
  endtask

  task set_limits(logic [15:0] pw, logic [15:0] azl, logic [15:0] ell);
    write_reg(CFG_POWER_FLOOR, pw);
    write_reg(CFG_AZ_LIMIT, azl);
    write_reg(CFG_EL_LIMIT, ell);
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    idle_cycles = 0;
    out_hold = 0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.power_in = '0;
    in_ch.doppler_in = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points under the reset limits: origin, straight behind, extremes.
    send_point(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b0);
    send_point(-16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b0);
    send_point(16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b1);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, -16'sd1, 1'b1);
    send_point(16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sh7fff, 16'sd0, 16'sd0, 16'sh5555, 16'shaaaa, 1'b0);
    drain();

    // Tight limits, including an ignored write to an unmapped index.
    set_limits(16'sd0, 16'd6434, 16'd3217);
    write_reg(CFG_UNMAPPED, 16'hffff);
    send_point(16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd256, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b0);
    send_point(16'sd256, 16'sd256, 16'sd0, 16'sd100, 16'sd0, 1'b1);
    send_point(16'sd256, 16'sd0, 16'sd256, 16'sd100, 16'sd0, 1'b0);
    random_points(PHASE_POINTS);
    drain();

    // Zero limits reject everything; maximal power threshold.
    set_limits(16'sh7fff, 16'd0, 16'd0);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    random_points(PHASE_POINTS);
    drain();

    // Over-wide register values keep only their low bits.
    set_limits(16'sh8000, 16'hffff, 16'hffff);
    random_points(PHASE_POINTS);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_limits(16'($urandom), 16'($urandom_range(0, 25736)),
                 16'($urandom_range(0, 25736)));
      random_points(PHASE_POINTS);
      drain();
    end

    // Final stretch without any idling on either side.
    set_limits(16'sh8000, 16'd25736, 16'd25736);
    quiet = 1'b1;
    random_points(PHASE_POINTS);
    drain();

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
design/rpg_pkg.sv
design/rpg_in_if.sv
design/rpg_out_if.sv
design/rpg_cfg_if.sv
design/rpg_sqrt.sv
design/rpg_cordic.sv
design/radar_point_gate.sv
bench/tb_top.sv
